@@ src/gtj_pkg.sv @@
package gtj_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned JYEAR_W = 15;
    localparam int unsigned DAYS_W  = 22;
    localparam int unsigned DOY_W   = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    localparam logic [DAYS_W-1:0]         DAY_BASE     = 22'd355666;
    localparam logic [13:0]               CYCLE33_DAYS = 14'd12053;
    localparam logic [10:0]               CYCLE4_DAYS  = 11'd1461;
    localparam logic [DOY_W-1:0]          YEAR_DAYS    = 9'd365;
    localparam logic [DOY_W-1:0]          HALF_DAYS    = 9'd186;
    localparam logic signed [JYEAR_W-1:0] JALALI_BASE  = -15'sd1595;
    localparam logic [JYEAR_W-1:0]        CYCLE33_YEARS = 15'd33;

    localparam logic [MONTH_W-1:0] FIRST_LATE_MONTH = 4'd7;
    localparam logic [DAY_W-1:0]   EARLY_MONTH_DAYS = 5'd31;
    localparam logic [DAY_W-1:0]   LATE_MONTH_DAYS  = 5'd30;

    // Reciprocal multipliers, rounded up, exact over the operand ranges used
    localparam int unsigned        DIV100_SH  = 21;
    localparam logic [14:0]        DIV100_MUL = 15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
    localparam int unsigned        DIV33_SH   = 36;
    localparam logic [22:0]        DIV33_MUL  =
        23'(((64'd1 << DIV33_SH) + 64'(CYCLE33_DAYS) - 64'd1) / 64'(CYCLE33_DAYS));
    localparam int unsigned        DIV4_SH    = 25;
    localparam logic [14:0]        DIV4_MUL   =
        15'(((64'd1 << DIV4_SH) + 64'(CYCLE4_DAYS) - 64'd1) / 64'(CYCLE4_DAYS));

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } greg_t;

    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
    } dc_t;

    typedef struct packed {
        logic                      ok;
        logic signed [JYEAR_W-1:0] year;
        logic [DOY_W-1:0]          doy;
    } yd_t;

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] res;
        unique case (month)
            4'd1:    res = 9'd0;
            4'd2:    res = 9'd31;
            4'd3:    res = 9'd59;
            4'd4:    res = 9'd90;
            4'd5:    res = 9'd120;
            4'd6:    res = 9'd151;
            4'd7:    res = 9'd181;
            4'd8:    res = 9'd212;
            4'd9:    res = 9'd243;
            4'd10:   res = 9'd273;
            4'd11:   res = 9'd304;
            4'd12:   res = 9'd334;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] res;
        unique case (month)
            4'd2:                                 res = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:              res = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: res = 5'd31;
            default:                              res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

@@ src/gtj_daycount.sv @@
module gtj_daycount (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gtj_pkg::greg_t in_date,
    output logic          out_valid,
    input  logic          out_ready,
    output gtj_pkg::dc_t  out_dc
);

    localparam int unsigned NSTG = 3;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    // stage A: range checks, year products and the century quotients
    logic [13:0] y2;
    logic [13:0] q4_sum;
    logic [13:0] a100_arg;
    logic [13:0] a400_sum;
    logic [28:0] p_y100;
    logic [28:0] p_a100;
    logic [26:0] p_a400;

    logic        oka_next, oka_reg;
    logic [13:0] y_reg;
    logic [3:0]  m_reg;
    logic [4:0]  d_reg;
    logic [7:0]  q100y_next, q100y_reg;
    logic [11:0] q4_next, q4_reg;
    logic [7:0]  a100_next, a100_reg;
    logic [5:0]  a400_next, a400_reg;
    logic [21:0] y365_next, y365_reg;

    // stage B: leap year, day limit and partial sum
    logic [14:0] cent;
    logic        leap;
    logic        okb_next, okb_reg;
    logic [21:0] s1_next, s1_reg;
    logic [7:0]  a100b_reg;
    logic [5:0]  a400b_reg;

    // stage C: century correction
    logic        okc_reg;
    logic [21:0] days_next, days_reg;

    always_comb
    begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        y2       = in_date.year + 14'(in_date.month > gtj_pkg::MONTH_FEB);
        q4_sum   = y2 + 14'd3;
        a100_arg = y2 + 14'd99;
        a400_sum = y2 + 14'd399;
        p_y100   = 29'(in_date.year) * 29'(gtj_pkg::DIV100_MUL);
        p_a100   = 29'(a100_arg) * 29'(gtj_pkg::DIV100_MUL);
        p_a400   = 27'(a400_sum[13:2]) * 27'(gtj_pkg::DIV100_MUL);

        q100y_next = p_y100[gtj_pkg::DIV100_SH +: 8];
        a100_next  = p_a100[gtj_pkg::DIV100_SH +: 8];
        a400_next  = p_a400[gtj_pkg::DIV100_SH +: 6];
        q4_next    = q4_sum[13:2];
        y365_next  = 22'(in_date.year) * 22'(gtj_pkg::YEAR_DAYS);
        oka_next   = (in_date.year != '0) && (in_date.year <= gtj_pkg::YEAR_MAX)
                  && (in_date.month != '0) && (in_date.month <= gtj_pkg::MONTH_MAX)
                  && (in_date.day != '0);
    end

    always_comb
    begin
        cent     = 15'(q100y_reg) * 15'd100;
        leap     = (y_reg[1:0] == 2'b00) && ((cent != 15'(y_reg)) || (q100y_reg[1:0] == 2'b00));
        okb_next = oka_reg && (d_reg <= gtj_pkg::month_len(m_reg, leap));
        s1_next  = gtj_pkg::DAY_BASE + y365_reg + 22'(q4_reg) + 22'(d_reg)
                 + 22'(gtj_pkg::days_before(m_reg));
    end

    assign days_next = s1_reg - 22'(a100b_reg) + 22'(a400b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            oka_reg   <= oka_next;
            y_reg     <= in_date.year;
            m_reg     <= in_date.month;
            d_reg     <= in_date.day;
            q100y_reg <= q100y_next;
            q4_reg    <= q4_next;
            a100_reg  <= a100_next;
            a400_reg  <= a400_next;
            y365_reg  <= y365_next;
        end
        if (rdy[1] && v_reg[0])
        begin
            okb_reg   <= okb_next;
            s1_reg    <= s1_next;
            a100b_reg <= a100_reg;
            a400b_reg <= a400_reg;
        end
        if (rdy[2] && v_reg[1])
        begin
            okc_reg  <= okb_reg;
            days_reg <= days_next;
        end
    end

    assign out_valid   = v_reg[NSTG-1];
    assign out_dc.ok   = okc_reg;
    assign out_dc.days = days_reg;

endmodule

@@ src/gtj_cycles.sv @@
module gtj_cycles (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  gtj_pkg::dc_t in_dc,
    output logic         out_valid,
    input  logic         out_ready,
    output gtj_pkg::yd_t out_yd
);

    localparam int unsigned NSTG = 5;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;

    // stage D: 33-year cycle quotient
    logic [44:0] p33;
    logic        okd_reg;
    logic [21:0] daysd_reg;
    logic [8:0]  q33_next, q33_reg;

    // stage E: 33-year remainder and base year
    logic [21:0] cyc_days;
    logic [14:0] cyc_years;
    logic        oke_reg;
    logic [13:0] rem33_next, rem33_reg;
    logic signed [14:0] jye_next, jye_reg;

    // stage F: 4-year cycle quotient
    logic [28:0] p4;
    logic        okf_reg;
    logic [13:0] rem33f_reg;
    logic signed [14:0] jyf_reg;
    logic [3:0]  q4_next, q4_reg;

    // stage G: 4-year remainder
    logic        okg_reg;
    logic [10:0] rem4_next, rem4_reg;
    logic signed [14:0] jyg_next, jyg_reg;

    // stage H: year within the 4-year cycle
    logic [10:0] t;
    logic [1:0]  yq;
    logic [10:0] t_left;
    logic        okh_reg;
    logic signed [14:0] jyh_next, jyh_reg;
    logic [8:0]  doy_next, doy_reg;

    always_comb
    begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    assign p33      = 45'(in_dc.days) * 45'(gtj_pkg::DIV33_MUL);
    assign q33_next = p33[gtj_pkg::DIV33_SH +: 9];

    assign cyc_days   = 22'(q33_reg) * 22'(gtj_pkg::CYCLE33_DAYS);
    assign rem33_next = 14'(daysd_reg - cyc_days);
    assign cyc_years  = 15'(q33_reg) * gtj_pkg::CYCLE33_YEARS;
    assign jye_next   = gtj_pkg::JALALI_BASE + $signed(cyc_years);

    assign p4      = 29'(rem33_reg) * 29'(gtj_pkg::DIV4_MUL);
    assign q4_next = p4[gtj_pkg::DIV4_SH +: 4];

    assign rem4_next = 11'(rem33f_reg - 14'(q4_reg) * 14'(gtj_pkg::CYCLE4_DAYS));
    assign jyg_next  = jyf_reg + $signed(15'(q4_reg) << 2);

    // past the first (366-day) year, drop the extra day and count 365-day years
    always_comb
    begin
        t      = rem4_reg - 11'd1;
        yq     = 2'(t >= 11'(gtj_pkg::YEAR_DAYS))
               + 2'(t >= 11'(gtj_pkg::YEAR_DAYS) * 11'd2)
               + 2'(t >= 11'(gtj_pkg::YEAR_DAYS) * 11'd3);
        t_left = t - 11'(yq) * 11'(gtj_pkg::YEAR_DAYS);
        if (rem4_reg > 11'(gtj_pkg::YEAR_DAYS))
        begin
            jyh_next = jyg_reg + $signed(15'(yq));
            doy_next = t_left[8:0];
        end
        else
        begin
            jyh_next = jyg_reg;
            doy_next = rem4_reg[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            okd_reg   <= in_dc.ok;
            daysd_reg <= in_dc.days;
            q33_reg   <= q33_next;
        end
        if (rdy[1] && v_reg[0])
        begin
            oke_reg   <= okd_reg;
            rem33_reg <= rem33_next;
            jye_reg   <= jye_next;
        end
        if (rdy[2] && v_reg[1])
        begin
            okf_reg    <= oke_reg;
            rem33f_reg <= rem33_reg;
            jyf_reg    <= jye_reg;
            q4_reg     <= q4_next;
        end
        if (rdy[3] && v_reg[2])
        begin
            okg_reg  <= okf_reg;
            rem4_reg <= rem4_next;
            jyg_reg  <= jyg_next;
        end
        if (rdy[4] && v_reg[3])
        begin
            okh_reg <= okg_reg;
            jyh_reg <= jyh_next;
            doy_reg <= doy_next;
        end
    end

    assign out_valid   = v_reg[NSTG-1];
    assign out_yd.ok   = okh_reg;
    assign out_yd.year = jyh_reg;
    assign out_yd.doy  = doy_reg;

    a_rem33_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] |-> rem33_reg < gtj_pkg::CYCLE33_DAYS)
        else $error("33-year remainder out of range");

    a_rem4_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> rem4_reg < gtj_pkg::CYCLE4_DAYS)
        else $error("4-year remainder out of range");

    a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[4] |-> doy_reg <= gtj_pkg::YEAR_DAYS)
        else $error("day of year out of range");

endmodule

@@ src/gtj_monthday.sv @@
module gtj_monthday (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gtj_pkg::yd_t        in_yd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic signed [14:0]  year,
    output logic [3:0]          month,
    output logic [4:0]          day
);

    logic        v_reg;
    logic        late;
    logic [8:0]  off;
    logic [4:0]  mlen;
    logic [2:0]  q;
    logic [8:0]  left;

    logic               ok_reg;
    logic signed [14:0] year_next, year_reg;
    logic [3:0]         month_next, month_reg;
    logic [4:0]         day_next, day_reg;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        late = in_yd.doy >= gtj_pkg::HALF_DAYS;
        off  = late ? (in_yd.doy - gtj_pkg::HALF_DAYS) : in_yd.doy;
        mlen = late ? gtj_pkg::LATE_MONTH_DAYS : gtj_pkg::EARLY_MONTH_DAYS;
        q    = '0;
        for (int k = 1; k <= 5; k++)
        begin
            if (off >= 9'(mlen) * 9'(k))
            begin
                q = q + 3'd1;
            end
        end
        left = off - 9'(q) * 9'(mlen);

        if (in_yd.ok)
        begin
            year_next  = in_yd.year;
            month_next = (late ? gtj_pkg::FIRST_LATE_MONTH : 4'd1) + 4'(q);
            day_next   = left[4:0] + 5'd1;
        end
        else
        begin
            year_next  = '0;
            month_next = '0;
            day_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ok_reg    <= in_yd.ok;
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign out_valid = v_reg;
    assign ok        = ok_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;

endmodule

@@ src/gregorian_to_jalali.sv @@
// Channel  Dir  Handshake          Content
// s_       in   s_tvalid/s_tready  s_tdata: Gregorian year, month, day
// m_       out  m_tvalid/m_tready  m_tdata: Jalali year, month, day; m_tuser: date valid
//
// Nine register stages: three form the day count, five split it by the 33-year,
// 4-year and 365-day cycles, one yields month and day. A transfer can be taken
// every cycle while m_tready does not stall the pipeline.
// rst_n clears the stage valid bits only; the data registers hold no reset.
// A stall at m_tready backs up stage by stage; empty stages still take transfers.
module gregorian_to_jalali (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [13:0] greg_year, [17:14] greg_month, [22:18] greg_day
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [14:0] jalali_year, [18:15] jalali_month, [23:19] jalali_day
    output logic        m_tuser    // [0] valid_res
);

    gtj_pkg::greg_t in_date;
    gtj_pkg::dc_t   dc;
    gtj_pkg::yd_t   yd;

    logic dc_valid, dc_ready;
    logic yd_valid, yd_ready;

    logic signed [14:0] jy;
    logic [3:0]         jm;
    logic [4:0]         jd;
    logic               res_ok;

    assign in_date.year  = s_tdata[13:0];
    assign in_date.month = s_tdata[17:14];
    assign in_date.day   = s_tdata[22:18];

    gtj_daycount u_daycount (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_date   (in_date),
        .out_valid (dc_valid),
        .out_ready (dc_ready),
        .out_dc    (dc)
    );

    gtj_cycles u_cycles (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dc_valid),
        .in_ready  (dc_ready),
        .in_dc     (dc),
        .out_valid (yd_valid),
        .out_ready (yd_ready),
        .out_yd    (yd)
    );

    gtj_monthday u_monthday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yd_valid),
        .in_ready  (yd_ready),
        .in_yd     (yd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ok        (res_ok),
        .year      (jy),
        .month     (jm),
        .day       (jd)
    );

    assign m_tdata = {jd, jm, jy};
    assign m_tuser = res_ok;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected date carries non-zero fields");

    a_month_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (jm != '0) && (jm <= 4'd12) && (jd != '0)
            && ((jm < gtj_pkg::FIRST_LATE_MONTH) ? (jd <= gtj_pkg::EARLY_MONTH_DAYS)
                                                 : (jd <= gtj_pkg::LATE_MONTH_DAYS)))
        else $error("Jalali month or day out of range");

endmodule

@@ tb/gregorian_to_jalali_tb.sv @@
`timescale 1ns / 1ps

module gregorian_to_jalali_tb;

    localparam int unsigned YEAR_W  = gtj_pkg::YEAR_W;
    localparam int unsigned MONTH_W = gtj_pkg::MONTH_W;
    localparam int unsigned DAY_W   = gtj_pkg::DAY_W;
    localparam int unsigned JYEAR_W = gtj_pkg::JYEAR_W;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_DATES   = 750;
    localparam int TAIL_CYCLES    = 30;

    typedef struct packed {
        logic                      ok;
        logic signed [JYEAR_W-1:0] year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
    } jdate_t;

    typedef struct packed {
        gtj_pkg::greg_t date;
        logic           fixed;
        jdate_t         want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    jdate_t   pending_jdates[$];
    dir_row_t directed_dates[$];
    int       errors       = 0;
    int       results_seen = 0;
    int       idle_cycles  = 0;

    gregorian_to_jalali uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int greg_month_days(input int y, input int m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:            return leap ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic int days_ahead_of_month(input int m);
        case (m)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            default: return 334;
        endcase
    endfunction

    function automatic jdate_t to_jalali(input gtj_pkg::greg_t g);
        jdate_t r;
        longint y, m, d, y2, n, jy;
        r = '0;
        y = g.year;
        m = g.month;
        d = g.day;
        if (y < 1 || y > 9999 || m < 1 || m > 12)
            return r;
        if (d < 1 || d > greg_month_days(int'(y), int'(m)))
            return r;
        y2 = (m > 2) ? y + 1 : y;
        n  = 355666 + 365 * y + (y2 + 3) / 4 - (y2 + 99) / 100 + (y2 + 399) / 400
           + d + days_ahead_of_month(int'(m));
        // peel off 33-year cycles, then 4-year cycles, then plain years
        jy = -1595 + 33 * (n / 12053);
        n  = n % 12053;
        jy = jy + 4 * (n / 1461);
        n  = n % 1461;
        if (n > 365)
        begin
            jy = jy + (n - 1) / 365;
            n  = (n - 1) % 365;
        end
        r.ok   = 1'b1;
        r.year = jy[JYEAR_W-1:0];
        if (n < 186)
        begin
            r.month = MONTH_W'(1 + n / 31);
            r.day   = DAY_W'(1 + n % 31);
        end
        else
        begin
            r.month = MONTH_W'(7 + (n - 186) / 30);
            r.day   = DAY_W'(1 + (n - 186) % 30);
        end
        return r;
    endfunction

    function automatic gtj_pkg::greg_t make_date(input int y, input int m, input int d);
        gtj_pkg::greg_t g;
        g.year  = YEAR_W'(y);
        g.month = MONTH_W'(m);
        g.day   = DAY_W'(d);
        return g;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic gtj_pkg::greg_t random_date();
        int y, m, d, mlen, kind;
        kind = $urandom_range(0, 99);
        y    = $urandom_range(1, 9999);
        m    = $urandom_range(1, 12);
        mlen = greg_month_days(y, m);
        d    = $urandom_range(1, mlen);
        if (kind < 15)
        begin
            // month ends and starts around leap and century years
            case ($urandom_range(0, 3))
                0:       y = $urandom_range(1, 4);
                1:       y = $urandom_range(9995, 9999);
                2:       y = 100 * $urandom_range(1, 99);
                default: y = 4 * $urandom_range(1, 2499);
            endcase
            mlen = greg_month_days(y, m);
            d    = $urandom_range(0, 1) ? mlen : 1;
        end
        else if (kind < 25)
        begin
            case ($urandom_range(0, 4))
                0:       y = 0;
                1:       y = $urandom_range(10000, 16383);
                2:       m = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15);
                3:       d = 0;
                default: d = (mlen < 31) ? $urandom_range(mlen + 1, 31) : 0;
            endcase
        end
        else if (kind < 33)
        begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        return make_date(y, m, d);
    endfunction

    task automatic add_row(input int y, input int m, input int d, input bit fixed,
                           input int jy, input int jm, input int jd);
        dir_row_t row;
        row.date       = make_date(y, m, d);
        row.fixed      = fixed;
        row.want.ok    = fixed && (jm != 0);
        row.want.year  = JYEAR_W'(jy);
        row.want.month = MONTH_W'(jm);
        row.want.day   = DAY_W'(jd);
        directed_dates.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Offer one date until it is taken; keep tvalid up when no gap follows
    task automatic send_date(input gtj_pkg::greg_t g, input jdate_t want, input bit quiet);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, g};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_jdates.push_back(want);
        gap = quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_jdates.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit quiet;
        gtj_pkg::greg_t g;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        // invalid dates: everything zero
        add_row(0,     1,  1,  1'b1, 0, 0, 0);
        add_row(10000, 1,  1,  1'b1, 0, 0, 0);
        add_row(16383, 15, 31, 1'b1, 0, 0, 0);
        add_row(0,     0,  0,  1'b1, 0, 0, 0);
        add_row(2024,  0,  1,  1'b1, 0, 0, 0);
        add_row(2024,  13, 1,  1'b1, 0, 0, 0);
        add_row(2024,  1,  0,  1'b1, 0, 0, 0);
        add_row(2023,  2,  29, 1'b1, 0, 0, 0);
        add_row(1900,  2,  29, 1'b1, 0, 0, 0);
        add_row(2023,  4,  31, 1'b1, 0, 0, 0);
        // new year on either side of the vernal equinox
        add_row(2000,  3,  20, 1'b1, 1379, 1, 1);
        add_row(2000,  3,  21, 1'b1, 1379, 1, 2);
        // year extremes, leap Februaries, Jalali half-year and year ends
        add_row(1,     1,  1,  1'b0, 0, 0, 0);
        add_row(1,     12, 31, 1'b0, 0, 0, 0);
        add_row(9999,  1,  1,  1'b0, 0, 0, 0);
        add_row(9999,  12, 31, 1'b0, 0, 0, 0);
        add_row(2000,  2,  29, 1'b0, 0, 0, 0);
        add_row(2024,  2,  29, 1'b0, 0, 0, 0);
        add_row(2024,  3,  19, 1'b0, 0, 0, 0);
        add_row(2024,  9,  21, 1'b0, 0, 0, 0);
        add_row(2024,  9,  22, 1'b0, 0, 0, 0);
        add_row(2024,  12, 31, 1'b0, 0, 0, 0);
        add_row(2025,  3,  20, 1'b0, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_dates[i])
            send_date(directed_dates[i].date,
                      directed_dates[i].fixed ? directed_dates[i].want
                                              : to_jalali(directed_dates[i].date),
                      1'b0);
        drain_results();

        quiet = 1'b0;
        for (int i = 0; i < RANDOM_DATES; i++)
        begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == 400)
                drain_results();
            g = random_date();
            send_date(g, to_jalali(g), quiet);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side back-pressure, with one long hold-off to fill the pipeline
    initial
    begin
        int  hold;
        int  tick;
        bit  quiet;
        bit  long_done;
        hold      = 0;
        tick      = 0;
        quiet     = 1'b0;
        long_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (!long_done && results_seen >= 120)
            begin
                long_done = 1'b1;
                hold      = 80;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                hold = quiet ? 0 : idle_gap();
                m_tready <= (hold == 0);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        jdate_t got;
        jdate_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ok    = m_tuser;
            got.year  = m_tdata[14:0];
            got.month = m_tdata[18:15];
            got.day   = m_tdata[23:19];
            if (pending_jdates.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %b %0d/%0d/%0d",
                                          got.ok, got.year, got.month, got.day));
            end
            else
            begin
                want = pending_jdates.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("result %0d valid_res %b, expected %b",
                                              results_seen, got.ok, want.ok));
                if (got.year !== want.year)
                    report_mismatch($sformatf("result %0d jalali_year %0d, expected %0d",
                                              results_seen, got.year, want.year));
                if (got.month !== want.month)
                    report_mismatch($sformatf("result %0d jalali_month %0d, expected %0d",
                                              results_seen, got.month, want.month));
                if (got.day !== want.day)
                    report_mismatch($sformatf("result %0d jalali_day %0d, expected %0d",
                                              results_seen, got.day, want.day));
            end
            results_seen++;
        end
    end

    // Stop when neither side has moved a transfer for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d results outstanding", pending_jdates.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
